[design/assert_macros.svh]
// assertion macros shared by the receiver design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SWSR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swsr assertion failed");

// next-cycle implication, checked out of reset
`define SWSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swsr assertion failed");

`endif

[design/swsr_pkg.sv]
// shared types and constants of the single-wire sensor frame receiver
`default_nettype none

package swsr_pkg;

  localparam int MaxEdges  = 50;
  localparam int FrameBits = 40;
  localparam int EdgeW     = $clog2(MaxEdges + 1);
  localparam int CntW      = 24;
  localparam int HighW     = 8;
  localparam int StartW    = 16;
  localparam int ValW      = 20;

  localparam logic [StartW-1:0] StartLowReset = 16'd1000;
  localparam logic [CntW-1:0]   TimeoutReset  = 24'd10000;
  localparam logic [HighW-1:0]  HighLimReset  = 8'd60;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_BITCOUNT = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_START_LOW = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_HIGH_LIM  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    status_t             status;
    logic [ValW-1:0]     humidity_x10;
    logic [ValW-1:0]     temperature_x10;
  } frame_res_t;

endpackage

`default_nettype wire

[design/swsr_frame_check.sv]
// frame judge: bit count, checksum and scaled readings of a received word
`default_nettype none

module swsr_frame_check
  import swsr_pkg::*;
(
  input  wire logic [FrameBits-1:0] frame,
  input  wire logic [EdgeW-1:0]     edge_count,
  output frame_res_t                res
);

  logic [7:0] b0, b1, b2, b3, b4, sum;
  logic [15:0] hum_raw, temp_raw;

  assign b0 = frame[39:32];
  assign b1 = frame[31:24];
  assign b2 = frame[23:16];
  assign b3 = frame[15:8];
  assign b4 = frame[7:0];
  assign sum = b0 + b1 + b2 + b3;
  assign hum_raw = {b0, b1};
  assign temp_raw = {b2, b3};

  always_comb begin
    res.humidity_x10    = ValW'({hum_raw, 3'b000}) + ValW'({hum_raw, 1'b0});
    res.temperature_x10 = ValW'({temp_raw, 3'b000}) + ValW'({temp_raw, 1'b0});
    if (edge_count != EdgeW'(FrameBits)) begin
      res.status = ST_BITCOUNT;
    end else if (sum != b4) begin
      res.status = ST_CHECKSUM;
    end else begin
      res.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

[design/single_wire_sensor_frame_receiver_core.sv]
// Single-wire humidity/temperature sensor receiver, top level.
// Input channel: one word per sample tick; in_tuser carries the action
// (tick, start a read, clear stored results), in_tdata bit 0 the sampled pin.
// Output channel: exactly one word per input word, in order: line drive,
// done flag, status, stored humidity and temperature times ten, good flag.
// Configuration channel: cfg_index selects start low ticks, timeout ticks or
// high run limit; always ready, other indexes are dropped.
// Throughput: one word per cycle while in_tready is high; all per-sample
// work is one registered pass from the sequencer registers to the output
// register.
// An output register plus a one-word skid register lets an input word be
// taken while a result waits; in_tready falls only when both hold a word.
// Reset (synchronous, rst_n low) sets the sequencer idle, clears counters,
// stored readings and flags, and loads the default register values.
// When the receiver stalls, results are held and the line state machine
// simply stops advancing; no sample is lost because none is accepted.
`default_nettype none
`include "assert_macros.svh"

module single_wire_sensor_frame_receiver_core
  import swsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] pin_level, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] drive_low, [1] done_res, [3:2] status, [23:4] humidity_x10,
  // [43:24] temperature_x10, [44] result_good, rest zero
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_FALL  = 3'd2,
    PH_LOW   = 3'd3,
    PH_HIGH  = 3'd4,
    PH_RECV  = 3'd5
  } phase_t;

  logic [StartW-1:0]    start_low_r;
  logic [CntW-1:0]      timeout_r;
  logic [HighW-1:0]     high_lim_r;

  phase_t               phase_r, phase_nxt;
  logic [CntW-1:0]      phase_cnt_r, phase_cnt_nxt;
  logic [HighW-1:0]     high_r, high_nxt;
  logic [CntW-1:0]      low_r, low_nxt;
  logic                 prev_r, prev_nxt;
  logic [EdgeW-1:0]     edge_r, edge_nxt;
  logic [FrameBits-1:0] shift_r, shift_nxt;
  logic [ValW-1:0]      hum_r, hum_nxt;
  logic [ValW-1:0]      temp_r, temp_nxt;
  logic                 good_r, good_nxt;

  logic                 out_valid_r, skid_valid_r;
  logic [47:0]          out_data_r, skid_data_r;

  logic                 accept, pop, pin;
  action_t              action;
  logic                 drive, done;
  status_t              status;
  logic [47:0]          res_word;

  logic [CntW-1:0]      cnt_inc;
  logic [HighW-1:0]     high_inc;
  logic [CntW-1:0]      low_inc;
  logic                 fall, bit_val, ending;
  logic [EdgeW-1:0]     edge_new;
  logic [FrameBits-1:0] shift_new;
  logic                 wait_level;
  phase_t               wait_next;
  frame_res_t           fres;

  assign accept    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign pin       = in_tdata[0];
  assign action    = action_t'(in_tuser);

  // receive datapath
  assign cnt_inc   = (phase_cnt_r == '1) ? phase_cnt_r : phase_cnt_r + 1'b1;
  assign high_inc  = (pin && high_r != '1) ? high_r + 1'b1 : high_r;
  assign low_inc   = (!pin && low_r != '1) ? low_r + 1'b1 : low_r;
  assign fall      = prev_r && !pin;
  assign bit_val   = {{(CntW-HighW){1'b0}}, high_inc} >= low_inc;
  assign shift_new = fall ? {shift_r[FrameBits-2:0], bit_val} : shift_r;
  assign edge_new  = fall ? edge_r + 1'b1 : edge_r;
  assign ending    = (high_inc > high_lim_r) || (fall && edge_new >= EdgeW'(MaxEdges));

  swsr_frame_check u_check (
    .frame      (shift_new),
    .edge_count (edge_new),
    .res        (fres)
  );

  always_comb begin
    wait_level = 1'b1;
    wait_next  = PH_LOW;
    case (phase_r)
      PH_LOW: begin
        wait_level = 1'b0;
        wait_next  = PH_HIGH;
      end
      PH_HIGH: begin
        wait_next = PH_RECV;
      end
      default: begin
        wait_level = 1'b1;
        wait_next  = PH_LOW;
      end
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    prev_nxt      = prev_r;
    edge_nxt      = edge_r;
    shift_nxt     = shift_r;
    hum_nxt       = hum_r;
    temp_nxt      = temp_r;
    good_nxt      = good_r;
    drive         = 1'b0;
    done          = 1'b0;
    status        = ST_OK;
    case (action)
      ACT_START: begin
        drive = 1'b1;
        if ({{(CntW-StartW){1'b0}}, start_low_r} <= CntW'(1)) begin
          phase_nxt     = PH_FALL;
          phase_cnt_nxt = '0;
        end else begin
          phase_nxt     = PH_START;
          phase_cnt_nxt = CntW'(1);
        end
      end
      ACT_CLEAR: begin
        hum_nxt  = '0;
        temp_nxt = '0;
        good_nxt = 1'b0;
        drive    = (phase_r == PH_START);
      end
      ACT_TICK: begin
        case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_IDLE;
          end
          PH_START: begin
            drive         = 1'b1;
            phase_cnt_nxt = cnt_inc;
            if (cnt_inc >= {{(CntW-StartW){1'b0}}, start_low_r}) begin
              phase_nxt     = PH_FALL;
              phase_cnt_nxt = '0;
            end
          end
          PH_FALL, PH_LOW, PH_HIGH: begin
            if (pin == wait_level) begin
              phase_cnt_nxt = cnt_inc;
              if (cnt_inc > timeout_r) begin
                phase_nxt     = PH_IDLE;
                phase_cnt_nxt = '0;
                done          = 1'b1;
                status        = ST_TIMEOUT;
              end
            end else begin
              phase_nxt     = wait_next;
              phase_cnt_nxt = '0;
              if (wait_next == PH_RECV) begin
                high_nxt  = '0;
                low_nxt   = '0;
                prev_nxt  = 1'b0;
                edge_nxt  = '0;
                shift_nxt = '0;
              end
            end
          end
          PH_RECV: begin
            high_nxt  = fall ? '0 : high_inc;
            low_nxt   = fall ? '0 : low_inc;
            edge_nxt  = edge_new;
            shift_nxt = shift_new;
            prev_nxt  = pin;
            if (ending) begin
              done          = 1'b1;
              status        = fres.status;
              phase_nxt     = PH_IDLE;
              phase_cnt_nxt = '0;
              if (fres.status == ST_OK) begin
                hum_nxt  = fres.humidity_x10;
                temp_nxt = fres.temperature_x10;
                good_nxt = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign res_word = {3'b000, good_nxt, temp_nxt, hum_nxt, status, done, drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      phase_cnt_r  <= '0;
      high_r       <= '0;
      low_r        <= '0;
      prev_r       <= 1'b0;
      edge_r       <= '0;
      shift_r      <= '0;
      hum_r        <= '0;
      temp_r       <= '0;
      good_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        phase_cnt_r <= phase_cnt_nxt;
        high_r      <= high_nxt;
        low_r       <= low_nxt;
        prev_r      <= prev_nxt;
        edge_r      <= edge_nxt;
        shift_r     <= shift_nxt;
        hum_r       <= hum_nxt;
        temp_r      <= temp_nxt;
        good_r      <= good_nxt;
      end
      if (skid_valid_r) begin
        if (pop) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || pop) begin
          out_data_r  <= res_word;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= res_word;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r <= StartLowReset;
      timeout_r   <= TimeoutReset;
      high_lim_r  <= HighLimReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_LOW: start_low_r <= cfg_data[StartW-1:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[CntW-1:0];
        CFG_HIGH_LIM:  high_lim_r  <= cfg_data[HighW-1:0];
        default:       high_lim_r  <= high_lim_r;
      endcase
    end
  end

  `SWSR_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r)
  `SWSR_ASSERT_IMPL(a_idle_cnt_zero, phase_r == PH_IDLE, phase_cnt_r == '0)
  `SWSR_ASSERT_IMPL(a_recv_edges, phase_r == PH_RECV, edge_r < EdgeW'(MaxEdges))
  `SWSR_ASSERT_NEXT(a_start_enters, accept && action == ACT_START,
                    phase_r == PH_START || phase_r == PH_FALL)
  `SWSR_ASSERT_IMPL(a_no_result_zero, !good_r, hum_r == '0 && temp_r == '0)

endmodule

`default_nettype wire

[sim/sensor_readout_checker.sv]
// predicts and checks every result word of the single-wire sensor receiver
`timescale 1ns / 1ps

module sensor_readout_checker
  import swsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output int               fail_count,
  output int               pending_words
);

  localparam int TenthsScale = 10;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_FALL,
    SEQ_LOW,
    SEQ_HIGH,
    SEQ_RECV
  } seq_t;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]      pad;
    logic            good;
    logic [ValW-1:0] temp_x10;
    logic [ValW-1:0] hum_x10;
    status_t         status;
    logic            done;
    logic            line_low;
  } sensor_word_t;

  logic [StartW-1:0]    low_ticks;
  logic [CntW-1:0]      timeout_lim;
  logic [HighW-1:0]     high_lim;

  seq_t                 seq;
  logic [CntW-1:0]      wait_count;
  logic [HighW-1:0]     high_run;
  logic [CntW-1:0]      low_run;
  logic                 last_level;
  logic [EdgeW-1:0]     edges;
  logic [FrameBits-1:0] frame_bits;
  logic [ValW-1:0]      hum_store;
  logic [ValW-1:0]      temp_store;
  logic                 good_flag;

  sensor_word_t         awaited_words[$];
  int                   mismatches = 0;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // one handshake wait phase; true on timeout
  function automatic logic wait_step(input logic level, input logic pin, input seq_t nxt);
    if (pin == level) begin
      wait_count = sat_inc(wait_count);
      if (wait_count > timeout_lim) begin
        seq = SEQ_IDLE;
        wait_count = '0;
        return 1'b1;
      end
    end else begin
      seq = nxt;
      wait_count = '0;
    end
    return 1'b0;
  endfunction

  task automatic predict_sensor_word(input logic [1:0] act, input logic pin,
                                     output sensor_word_t w);
    logic       ending;
    logic       timed_out;
    logic [7:0] sum;
    w = '0;
    timed_out = 1'b0;
    ending = 1'b0;
    case (act)
      ACT_START: begin
        seq = SEQ_START;
        wait_count = 24'd1;
        w.line_low = 1'b1;
        if (wait_count >= low_ticks) begin
          seq = SEQ_FALL;
          wait_count = '0;
        end
      end
      ACT_CLEAR: begin
        hum_store = '0;
        temp_store = '0;
        good_flag = 1'b0;
        if (seq == SEQ_START) w.line_low = 1'b1;
      end
      ACT_TICK: begin
        case (seq)
          SEQ_START: begin
            w.line_low = 1'b1;
            wait_count = sat_inc(wait_count);
            if (wait_count >= low_ticks) begin
              seq = SEQ_FALL;
              wait_count = '0;
            end
          end
          SEQ_FALL: timed_out = wait_step(1'b1, pin, SEQ_LOW);
          SEQ_LOW:  timed_out = wait_step(1'b0, pin, SEQ_HIGH);
          SEQ_HIGH: begin
            timed_out = wait_step(1'b1, pin, SEQ_RECV);
            if (seq == SEQ_RECV) begin
              high_run = '0;
              low_run = '0;
              last_level = 1'b0;
              edges = '0;
              frame_bits = '0;
            end
          end
          SEQ_RECV: begin
            if (pin) begin
              if (high_run != '1) high_run = high_run + 1'b1;
            end else begin
              low_run = sat_inc(low_run);
            end
            if (high_run > high_lim) ending = 1'b1;
            if (last_level && !pin) begin
              frame_bits = {frame_bits[FrameBits-2:0], (CntW'(high_run) >= low_run)};
              high_run = '0;
              low_run = '0;
              edges = edges + 1'b1;
              if (edges >= MaxEdges) ending = 1'b1;
            end
            last_level = pin;
            if (ending) begin
              w.done = 1'b1;
              sum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                  + frame_bits[15:8];
              if (edges != EdgeW'(FrameBits)) begin
                w.status = ST_BITCOUNT;
              end else if (sum != frame_bits[7:0]) begin
                w.status = ST_CHECKSUM;
              end else begin
                w.status = ST_OK;
                hum_store = ValW'(frame_bits[39:24] * TenthsScale);
                temp_store = ValW'(frame_bits[23:8] * TenthsScale);
                good_flag = 1'b1;
              end
              seq = SEQ_IDLE;
              wait_count = '0;
            end
          end
          default: seq = SEQ_IDLE;
        endcase
      end
      default: ;
    endcase
    if (timed_out) begin
      w.done = 1'b1;
      w.status = ST_TIMEOUT;
    end
    w.hum_x10 = hum_store;
    w.temp_x10 = temp_store;
    w.good = good_flag;
  endtask

  function automatic void check_field(input string what, input logic [ValW-1:0] want,
                                      input logic [ValW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    sensor_word_t got;
    sensor_word_t want;
    if (!rst_n) begin
      low_ticks = StartLowReset;
      timeout_lim = TimeoutReset;
      high_lim = HighLimReset;
      seq = SEQ_IDLE;
      wait_count = '0;
      high_run = '0;
      low_run = '0;
      last_level = 1'b0;
      edges = '0;
      frame_bits = '0;
      hum_store = '0;
      temp_store = '0;
      good_flag = 1'b0;
      awaited_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_LOW: low_ticks = cfg_data[StartW-1:0];
          CFG_TIMEOUT:   timeout_lim = cfg_data[CntW-1:0];
          CFG_HIGH_LIM:  high_lim = cfg_data[HighW-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = sensor_word_t'(out_tdata);
        if (awaited_words.size() == 0) begin
          $display("%0t ns: result word expected none actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = awaited_words.pop_front();
          check_field("drive_low", want.line_low, got.line_low);
          check_field("done_res", want.done, got.done);
          check_field("status", want.status, got.status);
          check_field("humidity_x10", want.hum_x10, got.hum_x10);
          check_field("temperature_x10", want.temp_x10, got.temp_x10);
          check_field("result_good", want.good, got.good);
          check_field("padding", want.pad, got.pad);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_sensor_word(in_tuser, in_tdata[0], want);
        awaited_words.push_back(want);
      end
    end
    pending_words <= awaited_words.size();
    fail_count <= mismatches;
  end

endmodule

[sim/tb_single_wire_sensor_frame_receiver_core.sv]
// stimulus, reset, clock and verdict for the single-wire sensor receiver
`timescale 1ns / 1ps

module tb_single_wire_sensor_frame_receiver_core
  import swsr_pkg::*;
();

  localparam logic [1:0] ActUnused   = 2'd3;
  localparam int         TargetWords = 925;
  localparam int         CycleLimit  = 400000;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_WRONG_COUNT,
    FR_OVERRUN,
    FR_TIMEOUT,
    FR_ABORT,
    FR_NOISE
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fail_count;
  int          pending_words;

  int          cycle_count = 0;
  int          words_sent = 0;
  logic        feed_steady = 1'b0;
  logic        take_steady = 1'b0;
  int          cur_low_ticks = 1000;
  int          cur_timeout = 10000;
  int          cur_high_lim = 60;

  single_wire_sensor_frame_receiver_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sensor_readout_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("single_wire_sensor_frame_receiver_core regression: fail");
    $finish;
  end

  // result side stalls
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) take_steady = ~take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_word(input logic [1:0] act, input logic pin);
    int gap;
    if ($urandom_range(0, 49) == 0) feed_steady = ~feed_steady;
    gap = feed_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {7'd0, pin};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // one line sample, now and then preceded by a clear or an unused code
  task automatic sample_line(input logic pin);
    if ($urandom_range(0, 39) == 0)
      send_word(($urandom_range(0, 1) != 0) ? ACT_CLEAR : ActUnused, 1'($urandom_range(0, 1)));
    send_word(ACT_TICK, pin);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(input int low_ticks, input int timeout, input int high_lim);
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    put_reg(CFG_START_LOW, 24'(low_ticks));
    put_reg(CFG_TIMEOUT, 24'(timeout));
    put_reg(CFG_HIGH_LIM, 24'(high_lim));
    cfg_valid <= 1'b0;
    cur_low_ticks = low_ticks;
    cur_timeout = timeout;
    cur_high_lim = high_lim;
  endtask

  // start, handshake and bit stream of one read, shaped by kind
  task automatic run_frame(input frame_kind_t kind);
    int          eff_low;
    int          n_bits;
    int          hi;
    int          lo;
    int          ph;
    int          k;
    int          stuck_phase;
    logic [39:0] frame;
    logic [7:0]  sum;
    logic        lvl;
    logic        bitval;
    frame[39:8] = $urandom;
    sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
    frame[7:0] = (kind == FR_BAD_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    stuck_phase = $urandom_range(0, 2);
    if (kind == FR_TIMEOUT && cur_timeout > 40) kind = FR_GOOD;
    if (cur_high_lim > 32 &&
        (kind == FR_GOOD || kind == FR_BAD_SUM || kind == FR_WRONG_COUNT))
      kind = FR_OVERRUN;
    eff_low = (cur_low_ticks == 0) ? 1 : cur_low_ticks;
    send_word(ACT_START, 1'($urandom_range(0, 1)));
    if (eff_low > 12) begin
      repeat ($urandom_range(10, 30)) sample_line(1'($urandom_range(0, 1)));
      return;
    end
    repeat (eff_low - 1) sample_line(1'($urandom_range(0, 1)));
    // fall, low and high phases of the sensor answer
    for (ph = 0; ph < 3; ph++) begin
      lvl = (ph != 1);
      if (kind == FR_TIMEOUT && ph == stuck_phase) begin
        repeat (cur_timeout + 1) sample_line(lvl);
        return;
      end
      repeat ($urandom_range(0, (cur_timeout < 3) ? cur_timeout : 3)) sample_line(lvl);
      sample_line(!lvl);
    end
    case (kind)
      FR_WRONG_COUNT: begin
        n_bits = $urandom_range(0, 48);
        if (n_bits >= FrameBits) n_bits++;
      end
      FR_OVERRUN: n_bits = MaxEdges;
      FR_ABORT:   n_bits = $urandom_range(0, 30);
      default:    n_bits = FrameBits;
    endcase
    for (k = 0; k < n_bits; k++) begin
      bitval = (k < FrameBits) ? frame[FrameBits-1-k] : 1'($urandom_range(0, 1));
      hi = $urandom_range(1, (cur_high_lim < 2) ? cur_high_lim : 2);
      lo = bitval ? $urandom_range(1, hi) : hi + 1;
      // the first bit also counts the falling edge sample
      if (k == 0) lo--;
      repeat (lo) sample_line(1'b0);
      repeat (hi) sample_line(1'b1);
    end
    if (kind == FR_ABORT) return;
    if (n_bits == MaxEdges) begin
      sample_line(1'b0);
    end else begin
      repeat ($urandom_range(1, 2)) sample_line(1'b0);
      repeat (cur_high_lim + 1) sample_line(1'b1);
    end
  endtask

  initial begin
    int          setting_no;
    int          frames_left;
    int          pick;
    frame_kind_t kind;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_TICK;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_LOW;
    cfg_data = '0;
    setting_no = 0;
    frames_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default settings: idle sample, unused code, clear while driving low
    send_word(ACT_TICK, 1'b1);
    send_word(ActUnused, 1'b1);
    send_word(ACT_START, 1'b0);
    send_word(ACT_CLEAR, 1'b1);
    send_word(ActUnused, 1'b0);

    load_settings(1, 1, 1);
    // timeout while waiting for the fall
    send_word(ACT_START, 1'b0);
    send_word(ACT_TICK, 1'b1);
    send_word(ACT_TICK, 1'b1);
    // restart during the low phase, then low timeout
    send_word(ACT_START, 1'b1);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_START, 1'b1);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_TICK, 1'b0);
    // timeout in the high phase
    send_word(ACT_START, 1'b0);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_TICK, 1'b1);
    send_word(ACT_TICK, 1'b1);
    send_word(ACT_TICK, 1'b1);
    // reception ended by a long high with no bits, clear in between
    send_word(ACT_START, 1'b1);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_TICK, 1'b1);
    send_word(ACT_TICK, 1'b0);
    send_word(ACT_CLEAR, 1'b0);
    send_word(ACT_TICK, 1'b1);
    send_word(ACT_TICK, 1'b1);

    while (words_sent < TargetWords) begin
      if (frames_left == 0) begin
        case (setting_no)
          0:       load_settings(0, 24'hFFFFFF, 255);
          1:       load_settings(16'hFFFF, 1, 1);
          2:       load_settings(1, 1, 1);
          default: load_settings($urandom_range(1, 4), $urandom_range(1, 6),
                                 $urandom_range(1, 6));
        endcase
        setting_no++;
        frames_left = $urandom_range(2, 3);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)      kind = FR_GOOD;
      else if (pick < 55) kind = FR_BAD_SUM;
      else if (pick < 65) kind = FR_WRONG_COUNT;
      else if (pick < 73) kind = FR_OVERRUN;
      else if (pick < 85) kind = FR_TIMEOUT;
      else if (pick < 92) kind = FR_ABORT;
      else                kind = FR_NOISE;
      if (kind == FR_NOISE) begin
        repeat ($urandom_range(5, 20)) begin
          pick = $urandom_range(0, 9);
          send_word((pick == 0) ? ACT_START : (pick == 1) ? ACT_CLEAR :
                    (pick == 2) ? ActUnused : ACT_TICK, 1'($urandom_range(0, 1)));
        end
      end else begin
        run_frame(kind);
      end
      frames_left--;
    end

    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0)
      $display("single_wire_sensor_frame_receiver_core regression: pass");
    else
      $display("single_wire_sensor_frame_receiver_core regression: fail");
    $finish;
  end

endmodule
